[hw/rtl/sfd_pkg.sv]
// Shared types and constants for the SYN flood rate detector.
// Used by every module of the block but sfd_ram; depends on nothing else.
package sfd_pkg;

  localparam int unsigned CntW        = 24;
  localparam int unsigned AddrW       = 32;
  localparam int unsigned MaxReports  = 63;
  localparam int unsigned RepW        = 6;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QPtrW       = 2;

  localparam logic [15:0] EtherIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [15:0] MinCapLen   = 16'd34;
  localparam logic [3:0]  MinHdrWords = 4'd5;
  localparam logic [16:0] EthTcpBytes = 17'd34;

  typedef enum logic [2:0] {
    EV_STARTED = 3'd0,
    EV_ONGOING = 3'd1,
    EV_DROPPED = 3'd2,
    EV_ENDED   = 3'd3,
    EV_HEAVY   = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    REG_SYN_THR  = 2'd0,
    REG_SRC_THR  = 2'd1,
    REG_COOLDOWN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CntW-1:0] syn_thr;
    logic [CntW-1:0] src_thr;
    logic [7:0]      cooldown;
  } cfg_t;

  typedef struct packed {
    logic             tick;
    logic [AddrW-1:0] src;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [CntW-1:0]  cnt;
  } slot_t;

  typedef struct packed {
    event_e           ev;
    logic [CntW-1:0]  rate;
    logic [AddrW-1:0] src;
    logic [CntW-1:0]  cnt;
    logic             last;
  } res_t;

endpackage

[hw/rtl/sfd_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; used for the source table.
module sfd_ram #(
  parameter int unsigned Width = 57,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/sfd_front.sv]
// Front end: accepts items and keeps only ticks and valid SYN packets.
// Depends on sfd_pkg.
module sfd_front (
  input  logic                      start_i,
  input  logic                      kind_i,
  input  logic [15:0]               capture_length_i,
  input  logic [15:0]               ether_type_i,
  input  logic [3:0]                header_words_i,
  input  logic [7:0]                protocol_i,
  input  logic                      syn_flag_i,
  input  logic                      ack_flag_i,
  input  logic [31:0]               source_addr_i,
  input  logic                      full_i,
  input  logic                      init_i,
  output logic                      busy_o,
  output logic                      push_o,
  output sfd_pkg::entry_t           entry_o
);

  logic        is_syn;
  logic [16:0] min_len;

  assign min_len = sfd_pkg::EthTcpBytes + {11'd0, header_words_i, 2'b00};
  assign is_syn  = (capture_length_i >= sfd_pkg::MinCapLen)
                && (ether_type_i == sfd_pkg::EtherIpv4)
                && (header_words_i >= sfd_pkg::MinHdrWords)
                && (protocol_i == sfd_pkg::ProtoTcp)
                && ({1'b0, capture_length_i} >= min_len)
                && syn_flag_i && !ack_flag_i;

  assign busy_o       = full_i | init_i;
  assign push_o       = start_i & !busy_o & (kind_i | is_syn);
  assign entry_o.tick = kind_i;
  assign entry_o.src  = source_addr_i;

endmodule

[hw/rtl/sfd_queue.sv]
// Short FIFO of classified items between the front and back ends.
// Depends on sfd_pkg.
module sfd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfd_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sfd_pkg::entry_t entry_o
);

  sfd_pkg::entry_t               fifo_q [sfd_pkg::QueueDepth];
  logic [sfd_pkg::QPtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sfd_pkg::QPtrW:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 3'(sfd_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = fifo_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop_i ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q + {2'd0, push_i} - {2'd0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[hw/rtl/sfd_back.sv]
// Back end: window counting, source table probing and tick sweeps.
// Depends on sfd_pkg and sfd_ram.
module sfd_back #(
  parameter int unsigned TableSlots = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sfd_pkg::cfg_t   cfg_i,
  input  logic            valid_i,
  input  sfd_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            init_o,
  output logic            res_valid_o,
  output sfd_pkg::res_t   res_o
);

  localparam int unsigned AW = $clog2(TableSlots);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_CHK   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 slot_q, slot_d;
  logic [AW:0]                   probe_q, probe_d, scan_q, scan_d;
  logic [sfd_pkg::AddrW-1:0]     src_q, src_d, fold;
  logic [sfd_pkg::CntW-1:0]      wc_q, wc_d, rate_q, rate_d;
  logic                          attack_q, attack_d, heavy_q, heavy_d, chk_q, chk_d;
  logic [7:0]                    wb_q, wb_d, wb_inc;
  logic [sfd_pkg::RepW-1:0]      nrep_q, nrep_d;
  sfd_pkg::res_t                 pend_q, pend_d, out_q, out_d;
  logic                          pend_v_q, pend_v_d, out_v_q, out_v_d;
  logic                          we, issue, hit;
  logic [AW-1:0]                 waddr, raddr;
  sfd_pkg::slot_t                wdata, rdata;

  sfd_ram #(
    .Width($bits(sfd_pkg::slot_t)),
    .Depth(TableSlots)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign fold   = entry_i.src ^ (entry_i.src >> 16);
  assign issue  = !scan_q[AW];
  assign wb_inc = (wb_q != 8'hFF) ? wb_q + 8'd1 : wb_q;
  assign hit    = heavy_q && chk_q && rdata.valid && (rdata.cnt >= cfg_i.src_thr)
               && (nrep_q < sfd_pkg::RepW'(sfd_pkg::MaxReports));
  assign pop_o  = (state_q == S_IDLE) && valid_i;
  assign init_o = (state_q == S_INIT);
  assign raddr  = (state_q == S_SCAN) ? scan_q[AW-1:0] : slot_q;

  always_comb begin
    state_d  = state_q;
    slot_d   = slot_q;
    probe_d  = probe_q;
    scan_d   = scan_q;
    src_d    = src_q;
    wc_d     = wc_q;
    rate_d   = rate_q;
    attack_d = attack_q;
    heavy_d  = heavy_q;
    chk_d    = 1'b0;
    wb_d     = wb_q;
    nrep_d   = nrep_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = 1'b0;
    we       = 1'b0;
    waddr    = scan_q[AW-1:0];
    wdata    = '0;
    case (state_q)
      S_INIT: begin
        we     = issue;
        scan_d = scan_q + 1'b1;
        if (!issue) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (valid_i) begin
          if (!entry_i.tick) begin
            if (wc_q != '1) begin
              wc_d = wc_q + 1'b1;
            end
            if (entry_i.src != '0) begin
              src_d   = entry_i.src;
              slot_d  = fold[AW-1:0];
              probe_d = '0;
              state_d = S_RD;
            end
          end else begin
            rate_d   = wc_q;
            wc_d     = '0;
            scan_d   = '0;
            nrep_d   = '0;
            heavy_d  = 1'b0;
            pend_v_d = 1'b0;
            pend_d   = '0;
            pend_d.rate = wc_q;
            state_d  = S_SCAN;
            if (wc_q >= cfg_i.syn_thr) begin
              wb_d      = '0;
              heavy_d   = 1'b1;
              pend_v_d  = 1'b1;
              pend_d.ev = attack_q ? sfd_pkg::EV_ONGOING : sfd_pkg::EV_STARTED;
              attack_d  = 1'b1;
            end else if (attack_q) begin
              wb_d     = wb_inc;
              pend_v_d = 1'b1;
              if (wb_inc >= cfg_i.cooldown) begin
                pend_d.ev = sfd_pkg::EV_ENDED;
                attack_d  = 1'b0;
              end else begin
                pend_d.ev = sfd_pkg::EV_DROPPED;
              end
            end
          end
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        waddr = slot_q;
        wdata.valid = 1'b1;
        wdata.addr  = src_q;
        if (!rdata.valid) begin
          we        = 1'b1;
          wdata.cnt = sfd_pkg::CntW'(1);
          state_d   = S_IDLE;
        end else if (rdata.addr == src_q) begin
          we        = 1'b1;
          wdata.cnt = (rdata.cnt != '1) ? rdata.cnt + 1'b1 : rdata.cnt;
          state_d   = S_IDLE;
        end else begin
          probe_d = probe_q + 1'b1;
          slot_d  = (slot_q == AW'(TableSlots - 1)) ? '0 : slot_q + 1'b1;
          state_d = (probe_d == (AW+1)'(TableSlots)) ? S_IDLE : S_RD;
        end
      end
      S_SCAN: begin
        we     = issue;
        chk_d  = issue;
        scan_d = issue ? scan_q + 1'b1 : scan_q;
        if (hit) begin
          if (pend_v_q) begin
            out_d      = pend_q;
            out_d.last = 1'b0;
            out_v_d    = 1'b1;
          end
          pend_d.ev   = sfd_pkg::EV_HEAVY;
          pend_d.rate = rate_q;
          pend_d.src  = rdata.addr;
          pend_d.cnt  = rdata.cnt;
          pend_d.last = 1'b0;
          pend_v_d    = 1'b1;
          nrep_d      = nrep_q + 1'b1;
        end
        if (!issue && !chk_q) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (pend_v_q) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          out_v_d    = 1'b1;
        end
        pend_v_d = 1'b0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    src_q  <= src_d;
    rate_q <= rate_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      probe_q  <= '0;
      scan_q   <= '0;
      wc_q     <= '0;
      attack_q <= 1'b0;
      heavy_q  <= 1'b0;
      chk_q    <= 1'b0;
      wb_q     <= '0;
      nrep_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      probe_q  <= probe_d;
      scan_q   <= scan_d;
      wc_q     <= wc_d;
      attack_q <= attack_d;
      heavy_q  <= heavy_d;
      chk_q    <= chk_d;
      wb_q     <= wb_d;
      nrep_q   <= nrep_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

`ifndef SYNTH
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register not one-hot");
  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !out_v_q) else $error("result during clearing pass");
  a_report_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nrep_q <= sfd_pkg::RepW'(sfd_pkg::MaxReports)) else $error("report cap exceeded");
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_INIT || state_q == S_CHK || state_q == S_SCAN))
    else $error("table written outside a write state");
  a_flush_ends_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |=> (state_q == S_IDLE && !pend_v_q))
    else $error("tick did not close cleanly");
`endif

endmodule

[hw/rtl/syn_flood_rate_detector.sv]
// Top level of the SYN flood rate detector: configuration registers and wiring.
// Depends on sfd_pkg, sfd_front, sfd_queue, sfd_back and sfd_ram.
//
// An item is taken when start is high and busy is low. A packet that is not a SYN
// is dropped at the input. SYNs and ticks go into a four-entry queue, and busy
// rises only while that queue is full or while the table is being cleared. In the
// back end a SYN is taken in the idle state and then goes through a read state and a
// check state for each slot it probes in the source table's RAM, which has one write
// and one read port; usually one or two slots are probed. A tick sweeps the whole
// table, one slot a cycle, and holds the back end through the scan and flush states.
// Heavy-source results are strobed on result_valid_o during the sweep, and the final
// result of the tick after it, from the flush state. Results cannot be held off. After
// reset the block clears the table with busy high. TABLE_SLOTS must be a power of two.
module syn_flood_rate_detector #(
  parameter int unsigned TABLE_SLOTS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [15:0] capture_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [3:0]  header_words_i,
  input  logic [7:0]  protocol_i,
  input  logic        syn_flag_i,
  input  logic        ack_flag_i,
  input  logic [31:0] source_addr_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  event_res_o,
  output logic [23:0] rate_o,
  output logic [31:0] heavy_source_o,
  output logic [23:0] heavy_count_o,
  output logic        last_o
);

  sfd_pkg::cfg_t   cfg_q;
  sfd_pkg::entry_t push_entry, head_entry;
  sfd_pkg::res_t   res;
  logic            push, full, pop, head_valid, init;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.syn_thr  <= 24'd50;
      cfg_q.src_thr  <= 24'd50;
      cfg_q.cooldown <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfd_pkg::REG_SYN_THR:  cfg_q.syn_thr  <= cfg_data_i;
        sfd_pkg::REG_SRC_THR:  cfg_q.src_thr  <= cfg_data_i;
        sfd_pkg::REG_COOLDOWN: cfg_q.cooldown <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sfd_front u_front (
    .start_i         (start),
    .kind_i          (kind_i),
    .capture_length_i(capture_length_i),
    .ether_type_i    (ether_type_i),
    .header_words_i  (header_words_i),
    .protocol_i      (protocol_i),
    .syn_flag_i      (syn_flag_i),
    .ack_flag_i      (ack_flag_i),
    .source_addr_i   (source_addr_i),
    .full_i          (full),
    .init_i          (init),
    .busy_o          (busy),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  sfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .entry_o(head_entry)
  );

  sfd_back #(
    .TableSlots(TABLE_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (head_valid),
    .entry_i    (head_entry),
    .pop_o      (pop),
    .init_o     (init),
    .res_valid_o(result_valid_o),
    .res_o      (res)
  );

  assign event_res_o    = res.ev;
  assign rate_o         = res.rate;
  assign heavy_source_o = res.src;
  assign heavy_count_o  = res.cnt;
  assign last_o         = res.last;

endmodule

[bench/syn_flood_rate_detector_test.sv]
// Self-checking testbench for the SYN flood rate detector: a directed table, a report-cap
// pass and random packet and tick items, each checked against a behavioural predictor.
// Depends on sfd_pkg and the syn_flood_rate_detector RTL.
`timescale 1ns / 100ps

module syn_flood_rate_detector_test;

  localparam int unsigned Slots     = 4096;
  localparam int unsigned SweepWait = Slots + 200;
  localparam int unsigned Watchdog  = 40000;
  localparam logic [23:0] CntMax    = 24'hFFFFFF;

  typedef struct packed {
    logic        kind;
    logic [15:0] cap_len;
    logic [15:0] etype;
    logic [3:0]  hwords;
    logic [7:0]  proto;
    logic        syn;
    logic        ack;
    logic [31:0] src;
  } pkt_t;

  typedef struct {
    pkt_t item;
    int   n_res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = 1'b0;
  logic [15:0] capture_length_i = '0;
  logic [15:0] ether_type_i = '0;
  logic [3:0]  header_words_i = '0;
  logic [7:0]  protocol_i = '0;
  logic        syn_flag_i = 1'b0;
  logic        ack_flag_i = 1'b0;
  logic [31:0] source_addr_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [2:0]  event_res_o;
  logic [23:0] rate_o;
  logic [31:0] heavy_source_o;
  logic [23:0] heavy_count_o;
  logic        last_o;

  syn_flood_rate_detector dut (.*);

  // Predictor state.
  logic [23:0] thr_syn, thr_src;
  logic [7:0]  cool_win;
  logic [23:0] win_syns;
  logic        flood_on;
  logic [7:0]  quiet_wins;
  logic        tab_used [Slots];
  logic [31:0] tab_addr [Slots];
  logic [23:0] tab_cnt [Slots];

  sfd_pkg::res_t expected_events[$];
  int   errors = 0;
  int   idle_pct = 0;
  int   idle_cnt = 0;
  logic [31:0] src_pool [16];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [11:0] home_of(logic [31:0] a);
    logic [31:0] h;
    h = a ^ (a >> 16);
    return h[11:0];
  endfunction

  task automatic count_source(logic [31:0] a);
    logic [11:0] s;
    s = home_of(a);
    if (a == 0) return;
    for (int i = 0; i < Slots; i++) begin
      if (!tab_used[s]) begin
        tab_used[s] = 1'b1;
        tab_addr[s] = a;
        tab_cnt[s] = 24'd1;
        return;
      end
      if (tab_addr[s] == a) begin
        if (tab_cnt[s] != CntMax) tab_cnt[s]++;
        return;
      end
      s++;
    end
  endtask

  function automatic sfd_pkg::res_t mk_res(sfd_pkg::event_e ev, logic [23:0] r,
                                           logic [31:0] a, logic [23:0] c);
    sfd_pkg::res_t x;
    x.ev = ev;
    x.rate = r;
    x.src = a;
    x.cnt = c;
    x.last = 1'b0;
    return x;
  endfunction

  task automatic flood_predict(pkt_t p, output int n);
    sfd_pkg::res_t outs[$];
    logic [23:0] r;
    logic [6:0]  hb;
    hb = {1'b0, p.hwords, 2'b00};
    n = 0;
    if (!p.kind) begin
      if (p.cap_len >= 34 && p.etype == sfd_pkg::EtherIpv4 && hb >= 20 &&
          p.proto == sfd_pkg::ProtoTcp && {1'b0, p.cap_len} >= 17'd34 + hb &&
          p.syn && !p.ack) begin
        if (win_syns != CntMax) win_syns++;
        count_source(p.src);
      end
      return;
    end
    r = win_syns;
    if (r >= thr_syn) begin
      quiet_wins = '0;
      outs.push_back(mk_res(flood_on ? sfd_pkg::EV_ONGOING : sfd_pkg::EV_STARTED, r,
                            '0, '0));
      flood_on = 1'b1;
      for (int i = 0; i < Slots && outs.size() < 1 + sfd_pkg::MaxReports; i++)
        if (tab_used[i] && tab_cnt[i] >= thr_src)
          outs.push_back(mk_res(sfd_pkg::EV_HEAVY, r, tab_addr[i], tab_cnt[i]));
    end else if (flood_on) begin
      if (quiet_wins != 8'hFF) quiet_wins++;
      if (quiet_wins >= cool_win) begin
        flood_on = 1'b0;
        outs.push_back(mk_res(sfd_pkg::EV_ENDED, r, '0, '0));
      end else begin
        outs.push_back(mk_res(sfd_pkg::EV_DROPPED, r, '0, '0));
      end
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    n = outs.size();
    foreach (outs[i]) expected_events.push_back(outs[i]);
    win_syns = '0;
    foreach (tab_used[i]) tab_used[i] = 1'b0;
  endtask

  task automatic send_item(pkt_t p, output int n);
    start <= 1'b1;
    kind_i <= p.kind;
    capture_length_i <= p.cap_len;
    ether_type_i <= p.etype;
    header_words_i <= p.hwords;
    protocol_i <= p.proto;
    syn_flag_i <= p.syn;
    ack_flag_i <= p.ack;
    source_addr_i <= p.src;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    flood_predict(p, n);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_wait();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_events.size() > 0) @(posedge clk_i);
    repeat (SweepWait) @(posedge clk_i);
  endtask

  task automatic write_reg(sfd_pkg::reg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      sfd_pkg::REG_SYN_THR: thr_syn = val;
      sfd_pkg::REG_SRC_THR: thr_src = val;
      default: cool_win = val[7:0];
    endcase
  endtask

  function automatic pkt_t syn_pkt(logic [31:0] a);
    pkt_t p;
    p = '{kind: 1'b0, cap_len: 16'd54, etype: sfd_pkg::EtherIpv4, hwords: 4'd5,
          proto: sfd_pkg::ProtoTcp, syn: 1'b1, ack: 1'b0, src: a};
    return p;
  endfunction

  function automatic pkt_t tick_pkt();
    pkt_t p;
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    p = r[$bits(pkt_t)-1:0];
    p.kind = 1'b1;
    return p;
  endfunction

  function automatic pkt_t random_pkt();
    pkt_t p;
    int sel;
    logic [95:0] r;
    sel = $urandom_range(99);
    if (sel < 12) return tick_pkt();
    if (sel < 30) begin
      r = {$urandom, $urandom, $urandom};
      p = r[$bits(pkt_t)-1:0];
      p.kind = 1'b0;
      return p;
    end
    p = syn_pkt(src_pool[$urandom_range(15)]);
    p.hwords = 4'($urandom_range(15, 5));
    p.cap_len = 16'(34 + 4 * int'(p.hwords) + $urandom_range(1500));
    if (sel > 92) p.ack = 1'b1;
    return p;
  endfunction

  task automatic random_phase(int pct, int n_items);
    int n;
    idle_pct = pct;
    for (int i = 0; i < n_items; i++) send_item(random_pkt(), n);
    drain_and_wait();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result ev=%0d rate=%0d src=%h cnt=%0d last=%b", $time,
                 event_res_o, rate_o, heavy_source_o, heavy_count_o, last_o);
        errors++;
      end else begin
        sfd_pkg::res_t e;
        e = expected_events.pop_front();
        if (event_res_o !== e.ev || rate_o !== e.rate || heavy_source_o !== e.src ||
            heavy_count_o !== e.cnt || last_o !== e.last) begin
          $display("%0t: expected ev=%0d rate=%0d src=%h cnt=%0d last=%b", $time,
                   e.ev, e.rate, e.src, e.cnt, e.last);
          $display("%0t: actual   ev=%0d rate=%0d src=%h cnt=%0d last=%b", $time,
                   event_res_o, rate_o, heavy_source_o, heavy_count_o, last_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > Watchdog) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t dir_rows[$];
    pkt_t p;
    int n;
    thr_syn = 24'd50;
    thr_src = 24'd50;
    cool_win = 8'd5;
    win_syns = '0;
    flood_on = 1'b0;
    quiet_wins = '0;
    foreach (tab_used[i]) tab_used[i] = 1'b0;
    for (int i = 0; i < 8; i++) begin
      src_pool[i] = $urandom;
      src_pool[i + 8] = src_pool[i] ^ 32'h0001_0001;
    end
    src_pool[15] = '0;

    p = syn_pkt(32'hC0A8_0001);
    dir_rows.push_back('{p, 0});
    dir_rows.push_back('{p, 0});
    dir_rows.push_back('{syn_pkt(32'h0), 0});
    p.ack = 1'b1;
    dir_rows.push_back('{p, 0});
    p = syn_pkt(32'h1); p.cap_len = 16'd33;
    dir_rows.push_back('{p, 0});
    p = syn_pkt(32'h1); p.etype = 16'h86DD;
    dir_rows.push_back('{p, 0});
    p = syn_pkt(32'h1); p.hwords = 4'd4;
    dir_rows.push_back('{p, 0});
    p = syn_pkt(32'h1); p.proto = 8'd17;
    dir_rows.push_back('{p, 0});
    p = syn_pkt(32'h1); p.hwords = 4'hF; p.cap_len = 16'd93;
    dir_rows.push_back('{p, 0});
    p.cap_len = 16'd94; p.src = 32'hFFFF_FFFF;
    dir_rows.push_back('{p, 0});
    p = '1; p.kind = 1'b0;
    dir_rows.push_back('{p, 0});
    p = syn_pkt(32'h5); p.syn = 1'b0;
    dir_rows.push_back('{p, 0});
    dir_rows.push_back('{tick_pkt(), 2});
    dir_rows.push_back('{tick_pkt(), 1});
    for (int i = 0; i < 3; i++) dir_rows.push_back('{syn_pkt(32'hA), 0});
    dir_rows.push_back('{tick_pkt(), 2});
    for (int i = 0; i < 3; i++) dir_rows.push_back('{syn_pkt(32'hB), 0});
    dir_rows.push_back('{tick_pkt(), 2});
    dir_rows.push_back('{tick_pkt(), 1});
    dir_rows.push_back('{tick_pkt(), 1});
    dir_rows.push_back('{tick_pkt(), 0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(sfd_pkg::REG_SYN_THR, 24'd3);
    write_reg(sfd_pkg::REG_SRC_THR, 24'd2);
    write_reg(sfd_pkg::REG_COOLDOWN, 24'd2);

    idle_pct = 37;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, n);
      if (n != dir_rows[i].n_res) begin
        $display("%0t: row %0d expected %0d results, predicted %0d", $time, i,
                 dir_rows[i].n_res, n);
        errors++;
      end
    end
    drain_and_wait();

    // More heavy sources than the report cap allows, one of them seen twice.
    write_reg(sfd_pkg::REG_SRC_THR, 24'd1);
    write_reg(sfd_pkg::REG_SYN_THR, 24'd1);
    idle_pct = 0;
    for (int i = 1; i <= int'(sfd_pkg::MaxReports) + 1; i++) send_item(syn_pkt(32'(i)), n);
    send_item(syn_pkt(32'h1), n);
    send_item(tick_pkt(), n);
    drain_and_wait();

    write_reg(sfd_pkg::REG_SYN_THR, 24'($urandom_range(6, 2)));
    write_reg(sfd_pkg::REG_SRC_THR, 24'($urandom_range(3, 1)));
    write_reg(sfd_pkg::REG_COOLDOWN, 24'd1);
    random_phase(37, 20);
    write_reg(sfd_pkg::REG_COOLDOWN, 24'd255);
    write_reg(sfd_pkg::REG_SYN_THR, 24'($urandom_range(5, 1)));
    random_phase(77, 20);
    write_reg(sfd_pkg::REG_SYN_THR, 24'hFFFFFF);
    write_reg(sfd_pkg::REG_SRC_THR, 24'hFFFFFF);
    random_phase(0, 10);
    write_reg(sfd_pkg::REG_SYN_THR, 24'($urandom_range(4, 1)));
    write_reg(sfd_pkg::REG_SRC_THR, 24'($urandom_range(2, 1)));
    write_reg(sfd_pkg::REG_COOLDOWN, 24'($urandom_range(4, 2)));
    random_phase(0, 15);

    if (errors == 0 && expected_events.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_ram.sv
hw/rtl/sfd_front.sv
hw/rtl/sfd_queue.sv
hw/rtl/sfd_back.sv
hw/rtl/syn_flood_rate_detector.sv
bench/syn_flood_rate_detector_test.sv
